FILE: rtl/core/mcfir_pkg.sv
// Shared widths, defaults and control types for the multichannel FIR core.
// No dependencies; imported by every module of the core.
package mcfir_pkg;

   // Payload and coefficient widths
   localparam int SAMPLE_W  = 16;
   localparam int CHAN_W    = 1;
   localparam int COEF_W    = 16;
   localparam int NUM_COEF  = 8;
   localparam int CSR_IDX_W = 3;

   // Datapath widths: exact Q2.30 products, room for eight of them summed
   localparam int PROD_W    = 2 * SAMPLE_W;
   localparam int ACC_W     = PROD_W + 3;
   localparam int RES_SHIFT = 16;

   // Default sizing of the core
   localparam int DEF_NUM_TAPS     = 8;
   localparam int DEF_NUM_CHANNELS = 2;

   // Control from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic clear;    // zero the accumulator at the start of a beat
      logic mul_en;   // history read data and coefficient are valid
   } mac_ctrl_type;

endpackage

FILE: rtl/core/mcfir_history.sv
// Sample history memory: one write port, one read port, registered read data.
// Per-entry valid bits make never-written entries read as zero. Uses mcfir_pkg.
module mcfir_history
   import mcfir_pkg::*;
#(
   parameter int DEPTH = DEF_NUM_TAPS * DEF_NUM_CHANNELS,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic signed [SAMPLE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic                       rd_vld,
   output logic signed [SAMPLE_W-1:0] rd_data
);

   logic signed [SAMPLE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]           written_ff;
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic                       rd_hit_ff;
   logic                       rd_vld_ff;

   // Memory array write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Valid bits, cleared at reset so the history starts at zero
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         rd_hit_ff  <= 1'b0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= rd_en;
         if (rd_en) begin
            rd_hit_ff <= written_ff[rd_addr];
         end
      end
   end

   assign rd_vld  = rd_vld_ff;
   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

   // Sequencer never writes and reads in the same cycle
   a_no_wr_rd_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("history write and read in the same cycle");

   // Read data valid follows a read request in the next cycle
   a_rd_latency: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> rd_vld)
      else $error("history read data not valid one cycle after request");

   // Data of a just-written entry reads back as written
   a_hit_after_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en ##1 (rd_en && rd_addr == $past(wr_addr))) |=> rd_data == $past(wr_data, 2))
      else $error("history read after write returned stale data");

endmodule

FILE: rtl/core/mcfir_mac.sv
// Shared multiply-accumulate unit: one tap product a cycle, registered, then summed.
// Halves, truncates and saturates the sum to Q1.15. Uses mcfir_pkg.
module mcfir_mac
   import mcfir_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  mac_ctrl_type               ctl,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic signed [COEF_W-1:0]   coef,
   output logic                       busy,
   output logic signed [SAMPLE_W-1:0] result
);

   logic signed [PROD_W-1:0]           prod_ff;
   logic                               prod_vld_ff;
   logic signed [ACC_W-1:0]            acc_ff;
   logic [ACC_W-1:PROD_W-1]            acc_hi;

   // Product stage
   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= sample * coef;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.mul_en;
      end
   end

   // Accumulate stage
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.clear) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   // Shift right by 16 (floor), then saturate: the sum fits when the bits
   // above bit 30 are all copies of the sign
   assign acc_hi = acc_ff[ACC_W-1:PROD_W-1];

   always_comb begin
      if (!acc_ff[ACC_W-1] && (|acc_hi)) begin
         result = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (acc_ff[ACC_W-1] && !(&acc_hi)) begin
         result = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         result = acc_ff[RES_SHIFT+SAMPLE_W-1:RES_SHIFT];
      end
   end

   assign busy = prod_vld_ff;

   // A new beat only starts once the product stage has drained
   a_clear_when_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |-> !prod_vld_ff)
      else $error("accumulator cleared with a product in flight");

   // Accumulator holds when nothing is added and no clear comes
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      (!ctl.clear && !prod_vld_ff) |=> $stable(acc_ff))
      else $error("accumulator changed without a product");

   // Every multiply leaves a product in the stage on the next cycle
   a_busy_after_mul: assert property (@(posedge clock) disable iff (reset)
      ctl.mul_en |=> busy)
      else $error("product stage empty after a multiply");

endmodule

FILE: rtl/core/multichannel_fir_filter_core.sv
// Multichannel direct-form FIR core: sequencer, write pointers, coefficients
// and output register. Instantiates mcfir_history and mcfir_mac; uses mcfir_pkg.
//
//   Channel  Direction  Ports                                  Beat
//   req      in         req_valid/req_stall, chan, sample      one tagged sample
//   rsp      out        rsp_valid/rsp_stall, chan, sample      one filtered sample
//   csr      in         csr_write_en, csr_index, csr_wdata     one coefficient write
//
// After its sample is accepted, a result passes through one history read per tap on
// the single read port, a multiply, an add, then the output register.
// A sample for a channel at or above NUM_CHANNELS returns zero without any tap reads.
// Reset is synchronous; history, write pointers and coefficients all start at zero.
// A stalled result waits in the output register while the next sample runs; the core
// holds its next sum until that register is free, and takes one sample at a time.
module multichannel_fir_filter_core
   import mcfir_pkg::*;
#(
   parameter int NUM_TAPS     = DEF_NUM_TAPS,
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CHAN_W-1:0]          req_chan_in,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [CHAN_W-1:0]          rsp_chan_out,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       csr_write_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic signed [COEF_W-1:0]   csr_wdata
);

   localparam int DEPTH = NUM_TAPS * NUM_CHANNELS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
   localparam int CIW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [PW-1:0] LAST_TAP = PW'(NUM_TAPS - 1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_READ  = 3'b010,
      S_DRAIN = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   logic [PW-1:0]              wp_ff [NUM_CHANNELS];
   logic signed [COEF_W-1:0]   coef_ff [NUM_COEF];
   logic [CHAN_W-1:0]          chan_ff;
   logic                       zero_ff;
   logic [PW-1:0]              rd_pos_ff;
   logic [PW-1:0]              tap_ff;
   logic [PW-1:0]              tap_d_ff;
   logic                       rsp_valid_ff;
   logic [CHAN_W-1:0]          rsp_chan_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;

   logic                       accept;
   logic                       in_range;
   logic [CIW-1:0]             chan_idx;
   logic [PW-1:0]              wp_cur;
   logic                       hist_we;
   logic [AW-1:0]              hist_waddr;
   logic                       hist_re;
   logic [AW-1:0]              hist_raddr;
   logic                       hist_vld;
   logic signed [SAMPLE_W-1:0] hist_data;
   mac_ctrl_type               mac_ctl;
   logic                       mac_busy;
   logic signed [SAMPLE_W-1:0] mac_result;
   logic                       pipe_empty;
   logic                       out_free;
   logic                       load_out;

   // Input handshake and write address of the accepted sample
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign in_range  = (32'(req_chan_in) < NUM_CHANNELS);
   assign chan_idx  = CIW'(req_chan_in);
   assign wp_cur    = wp_ff[chan_idx];
   assign hist_we   = accept && in_range;
   assign hist_waddr = AW'(AW'(req_chan_in) * AW'(NUM_TAPS)) + AW'(wp_cur);

   // Tap reads walk backward from the newest sample
   assign hist_re    = (state_ff == S_READ);
   assign hist_raddr = AW'(AW'(chan_ff) * AW'(NUM_TAPS)) + AW'(rd_pos_ff);

   assign mac_ctl.clear  = accept;
   assign mac_ctl.mul_en = hist_vld;

   assign pipe_empty = !hist_vld && !mac_busy;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign load_out   = (state_ff == S_DRAIN) && pipe_empty && out_free;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = in_range ? S_READ : S_DRAIN;
            end
         end
         S_READ: begin
            if (tap_ff == LAST_TAP) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Per-channel write pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            wp_ff[i] <= '0;
         end
      end else if (hist_we) begin
         wp_ff[chan_idx] <= (wp_cur == LAST_TAP) ? '0 : wp_cur + 1'b1;
      end
   end

   // Coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_write_en) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // Beat context and tap counters
   always_ff @(posedge clock) begin
      if (accept) begin
         chan_ff   <= req_chan_in;
         zero_ff   <= !in_range;
         rd_pos_ff <= wp_cur;
         tap_ff    <= '0;
      end else if (hist_re) begin
         rd_pos_ff <= (rd_pos_ff == '0) ? LAST_TAP : rd_pos_ff - 1'b1;
         tap_ff    <= tap_ff + 1'b1;
      end
      if (hist_re) begin
         tap_d_ff <= tap_ff;
      end
   end

   mcfir_history #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_history (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (req_sample_in),
      .rd_en   (hist_re),
      .rd_addr (hist_raddr),
      .rd_vld  (hist_vld),
      .rd_data (hist_data)
   );

   mcfir_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .sample (hist_data),
      .coef   (coef_ff[CSR_IDX_W'(tap_d_ff)]),
      .busy   (mac_busy),
      .result (mac_result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_chan_ff   <= chan_ff;
         rsp_sample_ff <= zero_ff ? '0 : mac_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_chan_out   = rsp_chan_ff;
   assign rsp_sample_out = rsp_sample_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   // An accepted beat always leaves idle on the next edge
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_READ || state_ff == S_DRAIN))
      else $error("sequencer stayed idle after accepting a beat");

   // Tap reads never run past the last tap
   a_tap_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (tap_ff <= LAST_TAP))
      else $error("tap counter beyond last tap");

   // The result is only loaded once the multiply-accumulate pipe is empty
   a_load_drained: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!hist_vld && !mac_busy && !hist_re))
      else $error("result loaded with taps in flight");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for multichannel_fir_filter_core: a queued driver,
// a checking monitor and a beat-level filter predictor.
// Depends on mcfir_pkg and the RTL of the core only.
module testbench
   import mcfir_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TAPS        = DEF_NUM_TAPS;
   localparam int CHANNELS    = DEF_NUM_CHANNELS;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = TAPS + 12;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct {
      logic [CHAN_W-1:0] chan;
      sample_type        sample;
      bit                hold_for_idle;  // sender waits for an empty pipeline first
   } sample_beat_type;

   typedef struct {
      logic [CHAN_W-1:0] chan;
      sample_type        sample;
   } filtered_beat_type;

   // DUT connections, all inputs known from time zero
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [CHAN_W-1:0]        req_chan_in = '0;
   sample_type               req_sample_in = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [CHAN_W-1:0]        rsp_chan_out;
   sample_type               rsp_sample_out;
   logic                     csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic signed [COEF_W-1:0] csr_wdata = '0;

   // Shared testbench state
   sample_beat_type   pending_samples[$];
   filtered_beat_type expected_filtered[$];
   bit                sending = 1'b0;
   int                error_count = 0;
   int                cycle_count = 0;

   // Predictor state: coefficients, per-channel history and write pointer
   logic signed [COEF_W-1:0] coef_shadow[NUM_COEF];
   sample_type               history[CHANNELS][TAPS];
   int unsigned              wr_pos[CHANNELS];

   multichannel_fir_filter_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_chan_in    (req_chan_in),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_chan_out   (rsp_chan_out),
      .rsp_sample_out (rsp_sample_out),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Filter one sample: store it, dot product newest-first, floor by 2^16, saturate; out-of-range channels give zero
   function automatic filtered_beat_type filter_sample(input logic [CHAN_W-1:0] ch,
                                                       input sample_type s);
      filtered_beat_type r;
      longint            acc;
      longint            res;
      int unsigned       pos;
      r.chan   = ch;
      r.sample = '0;
      if (ch >= CHANNELS) return r;
      acc = 0;
      pos = wr_pos[ch];
      history[ch][pos] = s;
      for (int k = 0; k < TAPS; k++) begin
         acc += longint'(history[ch][(pos + TAPS - k) % TAPS]) * longint'(coef_shadow[k]);
      end
      res = acc >>> RES_SHIFT;
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      wr_pos[ch] = (pos + 1) % TAPS;
      r.sample = res[SAMPLE_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      $display("ERROR @%0t: %s expected %0d got %0d", $realtime, what, want, got);
      error_count++;
   endtask

   // Driver: bursts of random length separated by random gaps
   int burst_left = 4;
   int gap_left   = 0;

   always @(posedge clock) begin
      sample_beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_filtered.push_back(filter_sample(req_chan_in, req_sample_in));
            sending = 1'b0;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0 &&
                         !(pending_samples[0].hold_for_idle && expected_filtered.size() > 0)) begin
               b = pending_samples.pop_front();
               sending = 1'b1;
               req_valid     <= 1'b1;
               req_chan_in   <= b.chan;
               req_sample_in <= b.sample;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                           : $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                           : $urandom_range(0, 3);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: a randomly chosen pattern, changed when its random timer runs out
   int stall_mode  = 0;
   int stall_timer = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_timer == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(64, 256);
         end else begin
            stall_timer--;
         end
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= stall_timer[2];
            end
         endcase
      end
   end

   // Monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      filtered_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_filtered.size() == 0) begin
            report_mismatch("result beat with nothing outstanding, chan", -1, rsp_chan_out);
         end else begin
            e = expected_filtered.pop_front();
            if (rsp_chan_out !== e.chan) report_mismatch("chan_out", e.chan, rsp_chan_out);
            if (rsp_sample_out !== e.sample) report_mismatch("sample_out", e.sample,
                                                             rsp_sample_out);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("multichannel_fir_filter_core: mismatch");
         $finish;
      end
   end

   task automatic write_coef(input int idx, input int value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx[CSR_IDX_W-1:0];
      csr_wdata    <= value[COEF_W-1:0];
      coef_shadow[idx] = value[COEF_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic push_sample(input int ch, input int s, input bit hold = 1'b0);
      sample_beat_type b;
      b.chan          = ch[CHAN_W-1:0];
      b.sample        = s[SAMPLE_W-1:0];
      b.hold_for_idle = hold;
      pending_samples.push_back(b);
   endtask

   // Block until every queued beat is accepted and every result is back
   task automatic drain;
      while (pending_samples.size() > 0 || sending || expected_filtered.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_all_coefs(input int value);
      for (int k = 0; k < NUM_COEF; k++) write_coef(k, value);
   endtask

   function automatic int pick_sample;
      case ($urandom_range(0, 9))
         0: return -32768;
         1: return 32767;
         2: return int'($urandom_range(0, 2)) - 1;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // Stimulus
   initial begin
      int k;
      int mode;
      for (int c = 0; c < CHANNELS; c++) begin
         wr_pos[c] = 0;
         for (int t = 0; t < TAPS; t++) history[c][t] = '0;
      end
      for (k = 0; k < NUM_COEF; k++) coef_shadow[k] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Coefficients at reset value: output is zero whatever comes in
      push_sample(0, 32767);
      push_sample(1, -32768);
      drain();

      // Distinct taps: impulses on both channels walk through the delay line
      write_coef(0, 32767);
      write_coef(1, -32768);
      write_coef(2, 16384);
      write_coef(3, -16384);
      write_coef(4, 1);
      write_coef(5, -1);
      write_coef(6, 12345);
      write_coef(7, -23456);
      push_sample(0, 32767);
      push_sample(1, -32768);
      for (k = 0; k < 4; k++) begin
         push_sample(0, 0, k == 2);
         push_sample(1, 0);
      end
      drain();

      // Full-scale negative everywhere: sum overflows, saturates positive
      set_all_coefs(-32768);
      for (k = 0; k < TAPS; k++) push_sample(1, -32768);
      drain();

      // Full-scale positive coefficients: channel 1, with a negative history, saturates negative
      set_all_coefs(32767);
      push_sample(0, -32768);
      push_sample(0, -32768);
      push_sample(1, 32767);
      push_sample(1, 32767);
      drain();

      // Truncation rounds toward minus infinity
      set_all_coefs(0);
      write_coef(0, 1);
      push_sample(0, -1);
      push_sample(1, 1);
      drain();

      // Random phases, each with its own coefficient set
      for (int phase = 0; phase < 5; phase++) begin
         mode = (phase == 4) ? 1 : $urandom_range(0, 3);
         for (k = 0; k < NUM_COEF; k++) begin
            case (mode)
               0: write_coef(k, $urandom_range(0, 65535));
               1: write_coef(k, ($urandom_range(0, 1) == 0) ? -32768 : 32767);
               2: write_coef(k, int'($urandom_range(0, 4095)) - 2048);
               default: write_coef(k, (k == phase % NUM_COEF) ? $urandom_range(0, 65535) : 0);
            endcase
         end
         for (int n = 0; n < 400; n++) push_sample($urandom_range(0, 1), pick_sample(),
                                                   $urandom_range(0, 299) == 0);
         drain();
      end

      if (error_count == 0) begin
         $display("multichannel_fir_filter_core: match");
      end else begin
         $display("multichannel_fir_filter_core: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/mcfir_pkg.sv
rtl/core/mcfir_history.sv
rtl/core/mcfir_mac.sv
rtl/core/multichannel_fir_filter_core.sv
sim/testbench.sv
